// File: hdl/ffpa_pkg.sv
// Shared types, codes and defaults for the first-fit pool allocator.
package ffpa_pkg;

    localparam int POOL_BYTES_DEF   = 65536;
    localparam int ALIGN_BYTES_DEF  = 8;
    localparam int HEADER_BYTES_DEF = 16;

    localparam int CFG_W  = 17;
    localparam int REQ_W  = 2;
    localparam int SIZE_W = 16;
    localparam int OFF_W  = 16;
    localparam int ST_W   = 3;
    localparam int USED_W = 17;

    localparam logic [CFG_W-1:0] POOL_SIZE_RST = 17'h10000;

    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESET = 2'd2;

    typedef enum logic [ST_W-1:0] {
        ST_DONE       = 3'd0,
        ST_ALLOC_FAIL = 3'd1,
        ST_RANGE      = 3'd2,
        ST_DOUBLE     = 3'd3,
        ST_NO_POOL    = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        OP_NOP, OP_ACCEPT, OP_SET_ST, OP_INIT, OP_CLR,
        OP_WALK_START, OP_WALK_NEXT, OP_TAKE_CUR,
        OP_RM_RDP, OP_RM_WRP, OP_RM_HEAD, OP_RM_RDN, OP_RM_WRN, OP_RM_DONE,
        OP_MAKE_F, OP_FIX_RD, OP_FIX_WR, OP_PUSH, OP_PUSH_WR, OP_AL_FIN,
        OP_FREE_RD, OP_FR_TAKE, OP_TAKE_N, OP_FN_MERGE, OP_RD_P, OP_TAKE_P,
        OP_FP_MERGE, OP_OUT_LOAD
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status st;
    } t_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic no_pool;
        logic size_zero;
        logic head_v;
        logic off_bad;
        logic fit;
        logic rd_hn;
        logic rd_start;
        logic rd_free;
        logic t_hpv;
        logic t_hn;
        logic split;
        logic nx_in;
        logic c_hp;
        logic xv;
        logic clr_last;
    } t_flags;

    // Header granule: largest power of two dividing both header and align sizes.
    function automatic int gran_bytes(input int hdr, input int aln);
        int v;
        v = hdr | aln;
        return v & -v;
    endfunction

endpackage

// File: hdl/ffpa_ctrl.sv
// Sequencer for the pool allocator: walks requests through datapath micro-ops.
module ffpa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  ffpa_pkg::t_flags i_flags,
    output ffpa_pkg::t_cmd  o_cmd
);
    import ffpa_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_WALK,
        S_RM0, S_RM1, S_RM2, S_RM3,
        S_SPLIT, S_FIX0, S_FIX1, S_PUSH, S_PUSH1, S_AL_FIN,
        S_FR_CHK, S_FN_CHK0, S_FN_CHK1, S_FN_MERGE,
        S_FP_CHK0, S_FP_CHK1, S_FP_MERGE, S_FR_FIN, S_FIN
    } t_state;

    typedef enum logic [1:0] {PH_ALLOC, PH_FNEXT, PH_FPREV} t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   r_from_req, n_from_req;
    logic   r_out_v;
    t_cmd   cmd;
    t_state after_rm, after_fix, after_push;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_cmd       = cmd;

    always_comb begin
        unique case (r_phase)
            PH_ALLOC: begin
                after_rm  = S_SPLIT;
                after_fix = S_PUSH;
                after_push = S_AL_FIN;
            end
            PH_FNEXT: begin
                after_rm  = S_FN_MERGE;
                after_fix = S_FP_CHK0;
                after_push = S_FR_FIN;
            end
            default: begin
                after_rm  = S_FP_MERGE;
                after_fix = S_PUSH;
                after_push = S_FR_FIN;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_from_req = r_from_req;
        cmd.op     = OP_NOP;
        cmd.st     = ST_DONE;
        unique case (r_state)
            S_CLEAR: begin
                cmd.op = OP_CLR;
                if (i_flags.clr_last) n_state = r_from_req ? S_FIN : S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.op  = OP_ACCEPT;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_flags.req == REQ_RESET) begin
                    cmd.op     = OP_INIT;
                    n_from_req = 1'b1;
                    n_state    = S_CLEAR;
                end else if (i_flags.req != REQ_ALLOC && i_flags.req != REQ_FREE) begin
                    cmd.op  = OP_SET_ST;
                    cmd.st  = ST_DONE;
                    n_state = S_FIN;
                end else if (i_flags.no_pool) begin
                    cmd.op  = OP_SET_ST;
                    cmd.st  = ST_NO_POOL;
                    n_state = S_FIN;
                end else if (i_flags.req == REQ_ALLOC) begin
                    if (i_flags.size_zero || !i_flags.head_v) begin
                        cmd.op  = OP_SET_ST;
                        cmd.st  = ST_ALLOC_FAIL;
                        n_state = S_FIN;
                    end else begin
                        cmd.op  = OP_WALK_START;
                        n_state = S_WALK;
                    end
                end else if (i_flags.off_bad) begin
                    cmd.op  = OP_SET_ST;
                    cmd.st  = ST_RANGE;
                    n_state = S_FIN;
                end else begin
                    cmd.op  = OP_FREE_RD;
                    n_state = S_FR_CHK;
                end
            end
            S_WALK: begin
                priority if (i_flags.fit) begin
                    cmd.op  = OP_TAKE_CUR;
                    n_phase = PH_ALLOC;
                    n_state = S_RM0;
                end else if (i_flags.rd_hn) begin
                    cmd.op = OP_WALK_NEXT;
                end else begin
                    cmd.op  = OP_SET_ST;
                    cmd.st  = ST_ALLOC_FAIL;
                    n_state = S_FIN;
                end
            end
            S_RM0: begin
                if (i_flags.t_hpv) begin
                    cmd.op  = OP_RM_RDP;
                    n_state = S_RM1;
                end else begin
                    cmd.op  = OP_RM_HEAD;
                    n_state = S_RM2;
                end
            end
            S_RM1: begin
                cmd.op  = OP_RM_WRP;
                n_state = S_RM2;
            end
            S_RM2: begin
                if (i_flags.t_hn) begin
                    cmd.op  = OP_RM_RDN;
                    n_state = S_RM3;
                end else begin
                    cmd.op  = OP_RM_DONE;
                    n_state = after_rm;
                end
            end
            S_RM3: begin
                cmd.op  = OP_RM_WRN;
                n_state = after_rm;
            end
            S_SPLIT: begin
                if (i_flags.split) begin
                    cmd.op  = OP_MAKE_F;
                    n_state = S_FIX0;
                end else begin
                    n_state = S_AL_FIN;
                end
            end
            S_FIX0: begin
                if (i_flags.nx_in) begin
                    cmd.op  = OP_FIX_RD;
                    n_state = S_FIX1;
                end else begin
                    n_state = after_fix;
                end
            end
            S_FIX1: begin
                cmd.op  = OP_FIX_WR;
                n_state = after_fix;
            end
            S_PUSH: begin
                cmd.op  = OP_PUSH;
                n_state = S_PUSH1;
            end
            S_PUSH1: begin
                if (i_flags.xv) cmd.op = OP_PUSH_WR;
                n_state = after_push;
            end
            S_AL_FIN: begin
                cmd.op  = OP_AL_FIN;
                n_state = S_FIN;
            end
            S_FR_CHK: begin
                priority if (!i_flags.rd_start) begin
                    cmd.op  = OP_SET_ST;
                    cmd.st  = ST_RANGE;
                    n_state = S_FIN;
                end else if (i_flags.rd_free) begin
                    cmd.op  = OP_SET_ST;
                    cmd.st  = ST_DOUBLE;
                    n_state = S_FIN;
                end else begin
                    cmd.op  = OP_FR_TAKE;
                    n_phase = PH_FNEXT;
                    n_state = S_FN_CHK0;
                end
            end
            S_FN_CHK0: begin
                if (i_flags.nx_in) begin
                    cmd.op  = OP_FIX_RD;
                    n_state = S_FN_CHK1;
                end else begin
                    n_state = S_FP_CHK0;
                end
            end
            S_FN_CHK1: begin
                if (i_flags.rd_free) begin
                    cmd.op  = OP_TAKE_N;
                    n_state = S_RM0;
                end else begin
                    n_state = S_FP_CHK0;
                end
            end
            S_FN_MERGE: begin
                cmd.op  = OP_FN_MERGE;
                n_state = S_FIX0;
            end
            S_FP_CHK0: begin
                if (i_flags.c_hp) begin
                    cmd.op  = OP_RD_P;
                    n_state = S_FP_CHK1;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_FP_CHK1: begin
                if (i_flags.rd_free) begin
                    cmd.op  = OP_TAKE_P;
                    n_phase = PH_FPREV;
                    n_state = S_RM0;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_FP_MERGE: begin
                cmd.op  = OP_FP_MERGE;
                n_state = S_FIX0;
            end
            S_FR_FIN: begin
                cmd.op  = OP_SET_ST;
                cmd.st  = ST_DONE;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_v || i_out_ready) begin
                    cmd.op  = OP_OUT_LOAD;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state    = S_CLEAR;
            n_from_req = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_phase    <= PH_ALLOC;
            r_from_req <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_from_req <= n_from_req;
            if (cmd.op == OP_OUT_LOAD) r_out_v <= 1'b1;
            else if (i_out_ready)      r_out_v <= 1'b0;
        end
    end

endmodule

// File: hdl/ffpa_dpath.sv
// Header memory, free-list registers and arithmetic of the pool allocator.
module ffpa_dpath #(
    parameter int POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffpa_pkg::ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ffpa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic [ffpa_pkg::REQ_W-1:0]   i_req_type,
    input  logic [ffpa_pkg::SIZE_W-1:0]  i_alloc_size,
    input  logic [ffpa_pkg::OFF_W-1:0]   i_free_offset,
    input  ffpa_pkg::t_cmd               i_cmd,
    output ffpa_pkg::t_flags             o_flags,
    output logic [ffpa_pkg::ST_W-1:0]    o_status,
    output logic [ffpa_pkg::OFF_W-1:0]   o_data_offset,
    output logic [ffpa_pkg::USED_W-1:0]  o_used_bytes
);
    import ffpa_pkg::*;

    localparam int G     = gran_bytes(HEADER_BYTES, ALIGN_BYTES);
    localparam int GS    = $clog2(G);
    localparam int DEPTH = (POOL_BYTES + G - 1) / G;
    localparam int IW    = $clog2(DEPTH);
    localparam int SW    = $clog2(POOL_BYTES + 1);
    localparam int XW    = (SW > 17 ? SW : 17) + 1;

    typedef struct packed {
        logic          start;
        logic          free;
        logic [SW-1:0] size;
        logic [IW-1:0] prev;
        logic          hp;
        logic [IW-1:0] nxt;
        logic          hn;
        logic [IW-1:0] prv;
        logic          hpv;
    } t_hdr;

    t_hdr r_mem [DEPTH];
    t_hdr r_rd, r_t, r_c;

    logic [CFG_W-1:0]  r_pool;
    logic [IW-1:0]     r_head, r_cur, r_ti, r_ci, r_x, r_clr;
    logic              r_hv, r_xv, r_size_zero;
    logic [SW-1:0]     r_used;
    logic [REQ_W-1:0]  r_req;
    logic [OFF_W-1:0]  r_off;
    logic [XW-1:0]     r_total;
    t_status           r_st;
    logic [OFF_W-1:0]  r_data;
    logic [ST_W-1:0]   r_o_st;
    logic [OFF_W-1:0]  r_o_data;
    logic [USED_W-1:0] r_o_used;

    logic [XW-1:0] cap_x, hbytes, rem, nx_x;
    logic [SW-1:0] cap;
    logic [IW-1:0] h_idx, nx_idx, nf_idx, raddr, waddr;
    logic          no_pool, we;
    t_hdr          wdata, init_h;
    t_hdr          new_f, taken_c, merged_c, t_unl;

    assign cap_x   = (XW'(r_pool) < XW'(POOL_BYTES)) ? XW'(r_pool) : XW'(POOL_BYTES);
    assign cap     = cap_x[SW-1:0];
    assign no_pool = cap_x < XW'(HEADER_BYTES);
    assign hbytes  = XW'(r_off) - XW'(HEADER_BYTES);
    assign h_idx   = hbytes[GS +: IW];
    assign rem     = XW'(r_t.size) - r_total;
    assign nx_x    = (XW'(r_ci) << GS) + XW'(r_c.size);
    assign nx_idx  = nx_x[GS +: IW];
    assign nf_idx  = r_ti + IW'(r_total >> GS);

    always_comb begin
        init_h       = '0;
        init_h.start = 1'b1;
        init_h.free  = 1'b1;
        init_h.size  = cap;
    end

    // next header images for the register updates below
    always_comb begin
        new_f         = '0;
        new_f.start   = 1'b1;
        new_f.free    = 1'b1;
        new_f.size    = rem[SW-1:0];
        new_f.prev    = r_ti;
        new_f.hp      = 1'b1;
        taken_c       = r_rd;
        taken_c.free  = 1'b1;
        taken_c.hn    = 1'b0;
        taken_c.hpv   = 1'b0;
        merged_c      = r_t;
        merged_c.size = r_t.size + r_c.size;
        t_unl         = r_t;
        t_unl.hn      = 1'b0;
        t_unl.hpv     = 1'b0;
    end

    always_comb begin
        o_flags.req       = r_req;
        o_flags.no_pool   = no_pool;
        o_flags.size_zero = r_size_zero;
        o_flags.head_v    = r_hv;
        o_flags.off_bad   = (XW'(r_off) < XW'(HEADER_BYTES)) || (XW'(r_off) > cap_x)
                            || (hbytes[GS-1:0] != '0);
        o_flags.fit       = XW'(r_rd.size) >= r_total;
        o_flags.rd_hn     = r_rd.hn;
        o_flags.rd_start  = r_rd.start;
        o_flags.rd_free   = r_rd.free;
        o_flags.t_hpv     = r_t.hpv;
        o_flags.t_hn      = r_t.hn;
        o_flags.split     = rem >= XW'(HEADER_BYTES);
        o_flags.nx_in     = nx_x < cap_x;
        o_flags.c_hp      = r_c.hp;
        o_flags.xv        = r_xv;
        o_flags.clr_last  = (r_clr == IW'(DEPTH - 1));
    end

    // memory port selection
    always_comb begin
        raddr = '0;
        waddr = '0;
        we    = 1'b0;
        wdata = r_rd;
        unique case (i_cmd.op)
            OP_CLR: begin
                we    = 1'b1;
                waddr = r_clr;
                wdata = (r_clr == '0 && !no_pool) ? init_h : '0;
            end
            OP_WALK_START: raddr = r_head;
            OP_WALK_NEXT:  raddr = r_rd.nxt;
            OP_RM_RDP:     raddr = r_t.prv;
            OP_RM_WRP: begin
                we        = 1'b1;
                waddr     = r_t.prv;
                wdata.nxt = r_t.nxt;
                wdata.hn  = r_t.hn;
            end
            OP_RM_RDN:     raddr = r_t.nxt;
            OP_RM_WRN: begin
                we        = 1'b1;
                waddr     = r_t.nxt;
                wdata.prv = r_t.prv;
                wdata.hpv = r_t.hpv;
            end
            OP_FIX_RD:     raddr = nx_idx;
            OP_FIX_WR: begin
                we         = 1'b1;
                waddr      = nx_idx;
                wdata.prev = r_ci;
                wdata.hp   = 1'b1;
            end
            OP_PUSH: begin
                raddr     = r_head;
                we        = 1'b1;
                waddr     = r_ci;
                wdata     = r_c;
                wdata.nxt = r_head;
                wdata.hn  = r_hv;
                wdata.hpv = 1'b0;
            end
            OP_PUSH_WR: begin
                we        = 1'b1;
                waddr     = r_x;
                wdata.prv = r_ci;
                wdata.hpv = 1'b1;
            end
            OP_AL_FIN: begin
                we         = 1'b1;
                waddr      = r_ti;
                wdata      = r_t;
                wdata.free = 1'b0;
            end
            OP_FREE_RD:    raddr = h_idx;
            OP_FN_MERGE: begin
                we          = 1'b1;
                waddr       = r_ti;
                wdata       = r_t;
                wdata.start = 1'b0;
            end
            OP_RD_P:       raddr = r_c.prev;
            OP_FP_MERGE: begin
                we          = 1'b1;
                waddr       = r_ci;
                wdata       = r_c;
                wdata.start = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= POOL_SIZE_RST;
            r_clr  <= '0;
            r_head <= '0;
            r_hv   <= 1'b0;
            r_used <= '0;
            r_xv   <= 1'b0;
            r_req  <= '0;
            r_st   <= ST_DONE;
        end else if (i_cfg_we) begin
            r_pool <= i_cfg_wdata;
            r_clr  <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_ACCEPT: begin
                    r_req       <= i_req_type;
                    r_off       <= i_free_offset;
                    r_size_zero <= (i_alloc_size == '0);
                    r_total     <= XW'(HEADER_BYTES)
                                   + ((XW'(i_alloc_size) + XW'(ALIGN_BYTES - 1))
                                      & ~XW'(ALIGN_BYTES - 1));
                    r_data      <= '0;
                end
                OP_SET_ST: r_st <= i_cmd.st;
                OP_INIT: begin
                    r_clr <= '0;
                    r_st  <= no_pool ? ST_NO_POOL : ST_DONE;
                end
                OP_CLR: begin
                    r_clr  <= r_clr + 1'b1;
                    r_used <= '0;
                    r_head <= '0;
                    r_hv   <= !no_pool;
                end
                OP_WALK_START: r_cur <= r_head;
                OP_WALK_NEXT:  r_cur <= r_rd.nxt;
                OP_TAKE_CUR: begin
                    r_t  <= r_rd;
                    r_ti <= r_cur;
                end
                OP_RM_HEAD: begin
                    r_head <= r_t.nxt;
                    r_hv   <= r_t.hn;
                end
                OP_RM_WRN, OP_RM_DONE: r_t <= t_unl;
                OP_MAKE_F: begin
                    r_c      <= new_f;
                    r_ci     <= nf_idx;
                    r_t.size <= r_total[SW-1:0];
                end
                OP_PUSH: begin
                    r_x    <= r_head;
                    r_xv   <= r_hv;
                    r_head <= r_ci;
                    r_hv   <= 1'b1;
                end
                OP_AL_FIN: begin
                    r_used <= r_used + r_t.size;
                    r_data <= OFF_W'((XW'(r_ti) << GS) + XW'(HEADER_BYTES));
                    r_st   <= ST_DONE;
                end
                OP_FR_TAKE: begin
                    r_c    <= taken_c;
                    r_ci   <= h_idx;
                    r_used <= r_used - r_rd.size;
                end
                OP_TAKE_N: begin
                    r_t  <= r_rd;
                    r_ti <= nx_idx;
                end
                OP_FN_MERGE: r_c.size <= r_c.size + r_t.size;
                OP_TAKE_P: begin
                    r_t  <= r_rd;
                    r_ti <= r_c.prev;
                end
                OP_FP_MERGE: begin
                    r_c  <= merged_c;
                    r_ci <= r_ti;
                end
                OP_OUT_LOAD: begin
                    r_o_st   <= r_st;
                    r_o_data <= r_data;
                    r_o_used <= USED_W'(r_used);
                end
                default: ;
            endcase
        end
    end

    assign o_status      = r_o_st;
    assign o_data_offset = r_o_data;
    assign o_used_bytes  = r_o_used;

endmodule

// File: hdl/first_fit_pool_allocator.sv
// Top level of the first-fit pool allocator with boundary-tag coalescing.
//
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+-----------------------------------
//  request | in        | i_in_valid / o_in_ready        | i_req_type i_alloc_size i_free_offset
//  result  | out       | o_out_valid / i_out_ready      | o_status o_data_offset o_used_bytes
//  config  | in        | i_cfg_we (no wait)             | i_cfg_wdata (pool_size)
//
// Allocate: decode, then a first-fit walk over the free list that reads one block header at a
//   time, then list and header updates (unlink, optional split and successor fix, push).
// Free: up to two list unlinks, two successor fixes and one push.
// Reset, a pool reset request and a pool_size write run a clearing pass over the header
//   memory, one entry per granule (8192 entries by default); no request is taken meanwhile.
// One request at a time; a finished result sits in the output register while the next
//   request is taken, and the next result waits until that transfer completes.
module first_fit_pool_allocator #(
    parameter int POOL_BYTES   = ffpa_pkg::POOL_BYTES_DEF,
    parameter int ALIGN_BYTES  = ffpa_pkg::ALIGN_BYTES_DEF,
    parameter int HEADER_BYTES = ffpa_pkg::HEADER_BYTES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [ffpa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [ffpa_pkg::REQ_W-1:0]   i_req_type,
    input  logic [ffpa_pkg::SIZE_W-1:0]  i_alloc_size,
    input  logic [ffpa_pkg::OFF_W-1:0]   i_free_offset,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [ffpa_pkg::ST_W-1:0]    o_status,
    output logic [ffpa_pkg::OFF_W-1:0]   o_data_offset,
    output logic [ffpa_pkg::USED_W-1:0]  o_used_bytes
);
    import ffpa_pkg::*;

    t_cmd   cmd;    // micro-op from the sequencer
    t_flags flags;  // decisions the sequencer branches on

    ffpa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_flags     (flags),
        .o_cmd       (cmd)
    );

    ffpa_dpath #(
        .POOL_BYTES   (POOL_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_alloc_size  (i_alloc_size),
        .i_free_offset (i_free_offset),
        .i_cmd         (cmd),
        .o_flags       (flags),
        .o_status      (o_status),
        .o_data_offset (o_data_offset),
        .o_used_bytes  (o_used_bytes)
    );

endmodule
